>>> hdl/idle_delimited_target_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// idle-delimited target frame receiver: assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef IDLE_DELIMITED_TARGET_FRAME_RECEIVER_DEFINES_SVH
`define IDLE_DELIMITED_TARGET_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IDFTR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define IDFTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define IDFTR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IDFTR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/idftr_pkg.sv
// ----------------------------------------------------------------------------
// idftr_pkg
// transaction types and codes for the target frame receiver
// ----------------------------------------------------------------------------
package idftr_pkg;

    localparam int FRAME_BYTES_DEF = 10;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_IDLE = 1'b1;

    localparam logic STATUS_GOOD     = 1'b0;
    localparam logic STATUS_CSUM_ERR = 1'b1;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic               status;
        logic        [15:0] box_width;
        logic        [15:0] box_height;
        logic        [7:0]  color_code;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_x;
    } t_out_item;

endpackage

>>> hdl/idle_delimited_target_frame_receiver.sv
// ----------------------------------------------------------------------------
// idle-delimited target frame receiver
// byte or short-frame idle: one transaction per cycle; full-frame idle: one shared
// adder sums bytes 0-8 in S_SUM, S_DONE loads the output once free, input stalled
// until loaded; sync active-low reset clears control and output valid, not the buffer
// ----------------------------------------------------------------------------
`include "idle_delimited_target_frame_receiver_defines.svh"

module idle_delimited_target_frame_receiver #(
    parameter int FRAME_BYTES = idftr_pkg::FRAME_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  idftr_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output idftr_pkg::t_out_item o_out_data
);
    import idftr_pkg::*;

    localparam int CNT_W    = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W    = $clog2(FRAME_BYTES);
    localparam int CHK_POS  = FRAME_BYTES - 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BYTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_BYTES - 2);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SUM  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state,     n_state;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [IDX_W-1:0] r_idx,       n_idx;
    logic [7:0]       r_sum,       n_sum;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_data,  n_out_data;
    logic [7:0]       r_buf [FRAME_BYTES];

    logic in_acc;
    logic buf_we;
    logic out_free;
    logic sum_last;
    logic done_hold;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign buf_we      = in_acc && (i_in_data.action == ACT_BYTE) && (r_count < CNT_FULL);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign sum_last    = (r_state == S_SUM) && (r_idx == IDX_LAST);
    assign done_hold   = (r_state == S_DONE) && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_sum       = r_sum;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.action == ACT_BYTE) begin
                        if (r_count < CNT_FULL) begin
                            n_count = r_count + CNT_W'(1);
                        end
                    end else begin
                        n_count = '0;
                        if (r_count == CNT_FULL) begin
                            n_state = S_SUM;
                            n_idx   = '0;
                            n_sum   = '0;
                        end
                    end
                end
            end
            S_SUM: begin
                n_sum = r_sum + r_buf[r_idx];
                n_idx = r_idx + IDX_W'(1);
                if (sum_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_data  = '0;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_sum == r_buf[CHK_POS]) begin
                        n_out_data.status     = STATUS_GOOD;
                        n_out_data.box_width  = {r_buf[0], r_buf[1]};
                        n_out_data.box_height = {r_buf[2], r_buf[3]};
                        n_out_data.color_code = r_buf[4];
                        n_out_data.offset_y   = $signed({r_buf[5], r_buf[6]});
                        n_out_data.offset_x   = $signed({r_buf[7], r_buf[8]});
                    end else begin
                        n_out_data.status = STATUS_CSUM_ERR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    // frame buffer, no reset
    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[r_count[IDX_W-1:0]] <= i_in_data.rx_byte;
        end
    end

    `IDFTR_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_FULL)
    `IDFTR_ASSERT_NOW(a_sum_cnt_clr, i_clk, i_rst_n, r_state == S_SUM, r_count == '0)
    `IDFTR_ASSERT_NEXT(a_sum_to_done, i_clk, i_rst_n, sum_last, r_state == S_DONE)
    `IDFTR_ASSERT_NEXT(a_done_wait, i_clk, i_rst_n, done_hold, r_state == S_DONE)

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: target frame receiver testbench
// drives byte and line-idle transactions into the receiver, predicts each
// frame result from a local frame buffer and byte count, and checks every
// result transaction field by field under random sender and receiver idling
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import idftr_pkg::*;

    localparam int BUF_DEPTH   = FRAME_BYTES_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 30;

    bit        clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    int tx_idle_pct  = 29;
    int rx_stall_pct = 68;

    int items_sent   = 0;
    int results_seen = 0;
    int good_frames  = 0;
    int bad_frames   = 0;
    int errors       = 0;

    // predicted receiver state
    logic [7:0]  rx_buf [BUF_DEPTH];
    int unsigned rx_count = 0;

    t_out_item pending_boxes [$];
    t_out_item want_box;

    idle_delimited_target_frame_receiver i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever begin
            #10 clk = ~clk;
        end
    end

    function automatic bit frame_step(input t_in_item it, output t_out_item res);
        logic [7:0] csum;
        int         k;
        res = '0;
        if (it.action == ACT_BYTE) begin
            if (rx_count < BUF_DEPTH) begin
                rx_buf[rx_count] = it.rx_byte;
                rx_count++;
            end
            return 1'b0;
        end
        if (rx_count != BUF_DEPTH) begin
            rx_count = 0;
            return 1'b0;
        end
        rx_count = 0;
        csum = '0;
        for (k = 0; k < BUF_DEPTH - 1; k++) begin
            csum += rx_buf[k];
        end
        if (csum != rx_buf[BUF_DEPTH - 1]) begin
            res.status = STATUS_CSUM_ERR;
            return 1'b1;
        end
        res.status     = STATUS_GOOD;
        res.box_width  = {rx_buf[0], rx_buf[1]};
        res.box_height = {rx_buf[2], rx_buf[3]};
        res.color_code = rx_buf[4];
        res.offset_y   = {rx_buf[5], rx_buf[6]};
        res.offset_x   = {rx_buf[7], rx_buf[8]};
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_item(input logic act, input logic [7:0] b);
        t_in_item  it;
        t_in_item  junk;
        t_out_item res;
        it.action  = act;
        it.rx_byte = b;
        while ($urandom_range(99) < tx_idle_pct) begin
            junk.action  = 1'($urandom_range(1));
            junk.rx_byte = 8'($urandom_range(255));
            @(negedge clk);
            in_valid <= 1'b0;
            in_data  <= junk;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= it;
        forever begin
            @(posedge clk);
            if (!in_stall) break;
        end
        items_sent++;
        if (frame_step(it, res)) begin
            pending_boxes.push_back(res);
            if (res.status == STATUS_GOOD) good_frames++;
            else bad_frames++;
        end
    endtask

    task automatic send_frame(input logic [7:0] fb [$], input logic [7:0] idle_byte);
        foreach (fb[k]) begin
            send_item(ACT_BYTE, fb[k]);
        end
        send_item(ACT_IDLE, idle_byte);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_boxes.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_frame();
        logic [7:0] fb [$];
        logic [7:0] csum;
        int         kind;
        kind = $urandom_range(99);
        csum = '0;
        if (kind < 84) begin
            repeat (BUF_DEPTH - 1) begin
                fb.push_back(pick_byte());
                csum += fb[$];
            end
            if (kind < 60) begin
                fb.push_back(csum);
            end else if (kind < 72) begin
                fb.push_back(csum + 8'($urandom_range(255, 1)));
            end else begin
                // overrun: trailing bytes must be dropped
                fb.push_back($urandom_range(1) ? csum : csum + 8'h01);
                repeat ($urandom_range(5, 1)) fb.push_back(pick_byte());
            end
        end else begin
            repeat ($urandom_range(BUF_DEPTH - 1, 0)) fb.push_back(pick_byte());
        end
        send_frame(fb, pick_byte());
    endtask

    task automatic test_good_frame();
        logic [7:0] fb [$];
        fb = '{8'hFF, 8'hFF, 8'h00, 8'h01, 8'hA5, 8'h80, 8'h00, 8'h7F, 8'hFF, 8'hA2};
        send_frame(fb, 8'hFF);
    endtask

    task automatic test_overrun_mismatch();
        logic [7:0] fb [$];
        fb = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h7F, 8'hFF, 8'h80, 8'h00, 8'hFD,
               8'hFC};
        send_frame(fb, 8'h00);
    endtask

    task automatic test_short_and_empty();
        logic [7:0] fb [$];
        fb = '{8'h55};
        send_frame(fb, 8'hAA);
        send_item(ACT_IDLE, 8'h3C);
    endtask

    task automatic test_drain_pause();
        send_random_frame();
        wait_for_drain();
        send_random_frame();
        wait_for_drain();
    endtask

    task automatic test_random_frames(input int n_items, input int tx_pct, input int rx_pct);
        int start;
        int frames;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        start  = items_sent;
        frames = 0;
        while (items_sent - start < n_items) begin
            send_random_frame();
            frames++;
            if (frames % 10 == 0) wait_for_drain();
        end
    endtask

    task automatic check_field(input string fname, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%h, got 0x%h", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_boxes.size() == 0) begin
                $display("%0t: unexpected result transaction: expected none, got %p",
                         $time, out_data);
                errors++;
            end else begin
                want_box = pending_boxes.pop_front();
                check_field("status", 16'(want_box.status), 16'(out_data.status));
                check_field("box_width", want_box.box_width, out_data.box_width);
                check_field("box_height", want_box.box_height, out_data.box_height);
                check_field("color_code", 16'(want_box.color_code),
                            16'(out_data.color_code));
                check_field("offset_y", want_box.offset_y, out_data.offset_y);
                check_field("offset_x", want_box.offset_x, out_data.offset_x);
                results_seen++;
            end
        end
    end

    // no transaction in either direction for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
            else quiet++;
        end
        $display("%0t: timeout, %0d results still pending", $time, pending_boxes.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_good_frame();
        test_overrun_mismatch();
        test_short_and_empty();
        test_drain_pause();
        test_random_frames(400, 29, 68);
        test_random_frames(400, 68, 29);
        test_random_frames(400, 0, 0);

        @(negedge clk);
        in_valid <= 1'b0;
        wait_for_drain();
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("sent %0d byte and idle transactions, checked %0d frame results",
                 items_sent, results_seen);
        $display("predicted %0d good frames and %0d checksum errors", good_frames, bad_frames);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
